FILE: rtl/kvsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvsp_pkg - shared types and constants for the snapshot record parser
// Phase encoding, result codes, field limits, queue entry and result structs,
// and the FNV-1a 64 byte step.
// ----------------------------------------------------------------------------
package kvsp_pkg;

    // result kinds
    localparam logic [2:0] KIND_START = 3'd0;
    localparam logic [2:0] KIND_KEY   = 3'd1;
    localparam logic [2:0] KIND_VALUE = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_FINAL = 3'd4;

    // final status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
    localparam logic [2:0] ST_BAD_KEY   = 3'd2;
    localparam logic [2:0] ST_BAD_VALUE = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;
    localparam logic [2:0] ST_HASH      = 3'd5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOW_MS      = 1'b1;

    // field limits
    localparam logic [31:0] TYPE_LOW      = 32'd1;
    localparam logic [31:0] TYPE_HIGH     = 32'd8;
    localparam logic [31:0] MAX_KEY_LEN   = 32'd1048576;
    localparam logic [31:0] MAX_VALUE_LEN = 32'd10485760;

    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    typedef enum logic [9:0] {
        PH_TYPE    = 10'b00_0000_0001,
        PH_EXPIRY  = 10'b00_0000_0010,
        PH_KEYLEN  = 10'b00_0000_0100,
        PH_KEY     = 10'b00_0000_1000,
        PH_VALLEN  = 10'b00_0001_0000,
        PH_VALUE   = 10'b00_0010_0000,
        PH_ENDED   = 10'b00_0100_0000,
        PH_STOPPED = 10'b00_1000_0000,
        PH_TRAILER = 10'b01_0000_0000,
        PH_DONE    = 10'b10_0000_0000
    } kvsp_phase_t;

    // at most one queue entry per byte; a record end may ride behind a value byte
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  ttype;
        logic [63:0] expiry;
        logic [7:0]  payload;
        logic [2:0]  status;
        logic [31:0] loaded;
        logic [31:0] expired;
        logic        done;
        logic        end_follows;
    } kvsp_entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  ttype;
        logic [63:0] expiry;
        logic [7:0]  payload;
        logic [2:0]  status;
        logic [31:0] loaded;
        logic [31:0] expired;
        logic        last;
        logic        done;
    } kvsp_result_t;

    // FNV-1a step; prime 0x100000001b3 = 2^40 + 2^8 + 0xb3, 0xb3 = 128+32+16+2+1
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/kvsp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvsp_parser - per-byte record parser and hash
// Folds each record-area byte into the FNV-1a hash, walks the record fields
// and builds at most one queue entry per accepted byte.
// ----------------------------------------------------------------------------
module kvsp_parser
    import kvsp_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 take,
    input  wire  [7:0]          data_byte,
    input  wire  [31:0]         data_length,
    input  wire  signed [63:0]  now_ms,
    output logic                push,
    output kvsp_entry_t         entry
);

    kvsp_phase_t phase_reg, phase_next;
    logic [2:0]  fidx_reg, fidx_next;
    logic [63:0] fshift_reg, fshift_next;
    logic [3:0]  rtype_reg, rtype_next;
    logic [63:0] rexp_reg, rexp_next;
    logic [23:0] left_reg, left_next;
    logic [31:0] pos_reg, pos_next;
    logic [63:0] hash_reg, hash_next;
    logic        skip_reg, skip_next;
    logic [2:0]  err_reg, err_next;
    logic [31:0] loaded_reg, loaded_next;
    logic [31:0] expired_reg, expired_next;

    kvsp_phase_t ph;
    logic [2:0]  fi;
    logic [63:0] fs;
    logic [63:0] full;
    logic [31:0] remain;
    logic        emit;

    function automatic logic [63:0] put_lane(input logic [63:0] acc, input logic [2:0] idx,
                                             input logic [7:0] b);
        logic [63:0] r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            if (idx == 3'(k))
            begin
                r[8*k +: 8] = acc[8*k +: 8] | b;
            end
        end
        return r;
    endfunction

    always_comb
    begin
        phase_next   = phase_reg;
        fidx_next    = fidx_reg;
        fshift_next  = fshift_reg;
        rtype_next   = rtype_reg;
        rexp_next    = rexp_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        hash_next    = hash_reg;
        skip_next    = skip_reg;
        err_next     = err_reg;
        loaded_next  = loaded_reg;
        expired_next = expired_reg;
        emit         = 1'b0;
        entry        = '0;
        ph           = phase_reg;
        fi           = fidx_reg;
        fs           = fshift_reg;
        remain       = data_length - pos_reg;

        if (phase_reg != PH_DONE)
        begin
            // record area exhausted: move on to the trailer
            if (phase_reg != PH_TRAILER && pos_reg >= data_length)
            begin
                if (err_reg == ST_OK &&
                    !(phase_reg inside {PH_TYPE, PH_ENDED, PH_STOPPED}))
                begin
                    err_next = ST_TRUNC;
                end
                ph = PH_TRAILER;
                fi = 3'd0;
                fs = '0;
            end
            full = put_lane(fs, fi, data_byte);

            if (ph == PH_TRAILER)
            begin
                if (fi == 3'd7)
                begin
                    phase_next    = PH_DONE;
                    fidx_next     = 3'd0;
                    fshift_next   = full;
                    emit          = 1'b1;
                    entry.kind    = KIND_FINAL;
                    entry.done    = 1'b1;
                    if (full != hash_reg)
                    begin
                        entry.status = ST_HASH;
                    end
                    else
                    begin
                        entry.status  = err_next;
                        entry.loaded  = loaded_reg;
                        entry.expired = expired_reg;
                    end
                end
                else
                begin
                    phase_next  = PH_TRAILER;
                    fidx_next   = fi + 3'd1;
                    fshift_next = full;
                end
            end
            else
            begin
                hash_next = fnv_step(hash_reg, data_byte);
                // short tail: not enough bytes left for a type field
                if (ph == PH_TYPE && fi == 3'd0 && remain < 32'd4)
                begin
                    ph = PH_ENDED;
                end
                pos_next    = pos_reg + 32'd1;
                phase_next  = ph;
                fidx_next   = fi;
                fshift_next = fs;
                entry.ttype = rtype_reg;

                case (ph)
                    PH_TYPE:
                    begin
                        if (fi >= 3'd3)
                        begin
                            fidx_next   = 3'd0;
                            fshift_next = '0;
                            if (full[31:0] < TYPE_LOW || full[31:0] > TYPE_HIGH)
                            begin
                                err_next   = ST_BAD_TYPE;
                                phase_next = PH_STOPPED;
                            end
                            else
                            begin
                                rtype_next = full[3:0];
                                phase_next = PH_EXPIRY;
                            end
                        end
                        else
                        begin
                            fidx_next   = fi + 3'd1;
                            fshift_next = full;
                        end
                    end
                    PH_EXPIRY:
                    begin
                        if (fi == 3'd7)
                        begin
                            fidx_next   = 3'd0;
                            fshift_next = '0;
                            rexp_next   = full;
                            skip_next   = ($signed(full) > 64'sd0) &&
                                          (now_ms > $signed(full));
                            phase_next  = PH_KEYLEN;
                        end
                        else
                        begin
                            fidx_next   = fi + 3'd1;
                            fshift_next = full;
                        end
                    end
                    PH_KEYLEN:
                    begin
                        if (fi >= 3'd3)
                        begin
                            fidx_next   = 3'd0;
                            fshift_next = '0;
                            if (full[31:0] == 32'd0 || full[31:0] > MAX_KEY_LEN)
                            begin
                                err_next   = ST_BAD_KEY;
                                phase_next = PH_STOPPED;
                            end
                            else
                            begin
                                left_next  = full[23:0];
                                phase_next = PH_KEY;
                                if (!skip_reg)
                                begin
                                    emit         = 1'b1;
                                    entry.kind   = KIND_START;
                                    entry.expiry = rexp_reg;
                                end
                            end
                        end
                        else
                        begin
                            fidx_next   = fi + 3'd1;
                            fshift_next = full;
                        end
                    end
                    PH_KEY:
                    begin
                        if (!skip_reg)
                        begin
                            emit          = 1'b1;
                            entry.kind    = KIND_KEY;
                            entry.payload = data_byte;
                        end
                        if (left_reg <= 24'd1)
                        begin
                            left_next   = '0;
                            phase_next  = PH_VALLEN;
                            fidx_next   = 3'd0;
                            fshift_next = '0;
                        end
                        else
                        begin
                            left_next = left_reg - 24'd1;
                        end
                    end
                    PH_VALLEN:
                    begin
                        if (fi >= 3'd3)
                        begin
                            fidx_next   = 3'd0;
                            fshift_next = '0;
                            if (full[31:0] > MAX_VALUE_LEN)
                            begin
                                err_next   = ST_BAD_VALUE;
                                phase_next = PH_STOPPED;
                            end
                            else if (full[23:0] == 24'd0)
                            begin
                                left_next  = '0;
                                phase_next = PH_TYPE;
                                if (skip_reg)
                                begin
                                    if (expired_reg != '1)
                                        expired_next = expired_reg + 32'd1;
                                end
                                else
                                begin
                                    if (loaded_reg != '1)
                                        loaded_next = loaded_reg + 32'd1;
                                    emit       = 1'b1;
                                    entry.kind = KIND_END;
                                end
                            end
                            else
                            begin
                                left_next  = full[23:0];
                                phase_next = PH_VALUE;
                            end
                        end
                        else
                        begin
                            fidx_next   = fi + 3'd1;
                            fshift_next = full;
                        end
                    end
                    PH_VALUE:
                    begin
                        if (!skip_reg)
                        begin
                            emit          = 1'b1;
                            entry.kind    = KIND_VALUE;
                            entry.payload = data_byte;
                        end
                        if (left_reg <= 24'd1)
                        begin
                            left_next   = '0;
                            phase_next  = PH_TYPE;
                            fidx_next   = 3'd0;
                            fshift_next = '0;
                            if (skip_reg)
                            begin
                                if (expired_reg != '1)
                                    expired_next = expired_reg + 32'd1;
                            end
                            else
                            begin
                                if (loaded_reg != '1)
                                    loaded_next = loaded_reg + 32'd1;
                                entry.end_follows = 1'b1;
                            end
                        end
                        else
                        begin
                            left_next = left_reg - 24'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else
        begin
            full = fs;
        end
    end

    assign push = take && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TYPE;
            fidx_reg    <= '0;
            fshift_reg  <= '0;
            rtype_reg   <= '0;
            rexp_reg    <= '0;
            left_reg    <= '0;
            pos_reg     <= '0;
            hash_reg    <= FNV_BASIS;
            skip_reg    <= 1'b0;
            err_reg     <= ST_OK;
            loaded_reg  <= '0;
            expired_reg <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            fidx_reg    <= fidx_next;
            fshift_reg  <= fshift_next;
            rtype_reg   <= rtype_next;
            rexp_reg    <= rexp_next;
            left_reg    <= left_next;
            pos_reg     <= pos_next;
            hash_reg    <= hash_next;
            skip_reg    <= skip_next;
            err_reg     <= err_next;
            loaded_reg  <= loaded_next;
            expired_reg <= expired_next;
        end
    end

    // once done, the parser never leaves done until reset
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("parser left done phase");

    // a final verdict is only pushed as the parser enters done
    a_final_enters_done: assert property (@(posedge clk) disable iff (!rst_n)
        push && entry.kind == KIND_FINAL |=> phase_reg == PH_DONE)
        else $error("final result without done phase");

    // nothing is pushed once the stream is finished
    a_no_push_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |-> !push)
        else $error("request pushed after final verdict");

endmodule
`default_nettype wire

FILE: rtl/kvsp_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvsp_outq - result queue
// Holds one entry per producing byte; an entry flagged with a trailing record
// end is presented as two results over two handshakes.
// ----------------------------------------------------------------------------
module kvsp_outq
    import kvsp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          push,
    input  kvsp_entry_t  entry,
    output logic         full,
    output logic         out_valid,
    input  wire          out_ready,
    output kvsp_result_t res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    kvsp_entry_t   mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          sub_reg, sub_next;
    kvsp_entry_t   head;
    logic          pop;
    logic          fire;

    assign head      = mem[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign fire      = out_valid && out_ready;
    assign pop       = fire && (sub_reg || !head.end_follows);

    always_comb
    begin
        res = '0;
        if (sub_reg)
        begin
            // trailing record end of a last value byte
            res.kind  = KIND_END;
            res.ttype = head.ttype;
            res.last  = 1'b1;
        end
        else
        begin
            res.kind    = head.kind;
            res.ttype   = head.ttype;
            res.expiry  = head.expiry;
            res.payload = head.payload;
            res.status  = head.status;
            res.loaded  = head.loaded;
            res.expired = head.expired;
            res.done    = head.done;
            res.last    = !head.end_follows;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        sub_next    = sub_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (!push && pop)
            count_next = count_reg - CW'(1);
        if (fire)
            sub_next = !sub_reg && head.end_follows;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    // second half only exists behind an entry that carries a record end
    a_sub_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (count_reg != '0) && head.end_follows)
        else $error("record end half without owning entry");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not grow on push");

endmodule
`default_nettype wire

FILE: rtl/kv_snapshot_record_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kv_snapshot_record_parser_top - snapshot record parser
// Hashes and parses a snapshot byte stream, emitting record start, key bytes,
// value bytes, record end and a final verdict with status and counts.
//
//   channel  signals                             direction  moves
//   in       in_valid/in_ready, data_byte        sink       one stream byte
//   out      out_valid/out_ready, result fields  source     one result
//   cfg      cfg_valid/cfg_ready, index, data    sink       register write
//
// One byte is accepted per cycle while the queue has room; parse and hash update finish in that cycle.
// A last value byte of a loaded record yields two results over two handshakes on the result port.
// FIFO_DEPTH queue entries sit between parser and result port; in_ready
// drops only when the queue is full.
// Reset clears all state but the queue storage, sets the hash to the FNV basis; no clearing pass.
// ----------------------------------------------------------------------------
module kv_snapshot_record_parser_top
    import kvsp_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  [7:0]           data_byte,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [2:0]           result_kind,
    output logic [3:0]           table_type,
    output logic signed [63:0]   expiry,
    output logic [7:0]           payload_byte,
    output logic [2:0]           status,
    output logic [31:0]          live_count,
    output logic [31:0]          expired_count,
    output logic                 run_last,
    output logic                 stream_done,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [63:0]          cfg_data
);

    logic [31:0]        dlen_reg;
    logic signed [63:0] now_reg;
    logic               take;
    logic               push;
    logic               q_full;
    kvsp_entry_t        entry;
    kvsp_result_t       res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign take      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlen_reg <= '0;
            now_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DATA_LENGTH: dlen_reg <= cfg_data[31:0];
                CFG_NOW_MS:      now_reg  <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    kvsp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .data_byte   (data_byte),
        .data_length (dlen_reg),
        .now_ms      (now_reg),
        .push        (push),
        .entry       (entry)
    );

    kvsp_outq #(
        .DEPTH (FIFO_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry     (entry),
        .full      (q_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign result_kind   = res.kind;
    assign table_type    = res.ttype;
    assign expiry        = $signed(res.expiry);
    assign payload_byte  = res.payload;
    assign status        = res.status;
    assign live_count    = res.loaded;
    assign expired_count = res.expired;
    assign run_last      = res.last;
    assign stream_done   = res.done;

endmodule
`default_nettype wire
